FILE: src/deq_pkg.sv
// shared types, constants and slot arithmetic for the double-ended queue
// no dependencies; imported by double_ended_queue_unit and deq_ctrl, not by deq_ram

package deq_pkg;

    localparam int DEPTH   = 32;
    localparam int PTR_W   = $clog2(DEPTH);
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int SUM_W   = CNT_W + 1;
    localparam int VALUE_W = 32;
    localparam int ACT_W   = 3;
    localparam int STAT_W  = 2;

    typedef enum logic [ACT_W-1:0] {
        ACT_PUSH_FRONT = 3'd0,
        ACT_PUSH_REAR  = 3'd1,
        ACT_LIST       = 3'd2,
        ACT_POP_FRONT  = 3'd3,
        ACT_POP_REAR   = 3'd4
    } t_action;

    typedef enum logic [STAT_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_POP,
        S_LIST
    } t_state;

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        t_status            status;
        logic               last;
    } t_result;

    typedef struct packed {
        logic [CNT_W-1:0] count;
        logic             idle;
    } t_deq_stat;

    // ring slot that lies off entries after base, wrapping at DEPTH
    function automatic logic [PTR_W-1:0] slot_add(logic [PTR_W-1:0] base,
                                                  logic [CNT_W-1:0] off);
        logic [SUM_W-1:0] sum;
        sum = SUM_W'(base) + SUM_W'(off);
        if (sum >= SUM_W'(DEPTH)) begin
            sum = sum - SUM_W'(DEPTH);
        end
        return sum[PTR_W-1:0];
    endfunction

endpackage

FILE: src/double_ended_queue_unit.sv
// double-ended queue of signed 32-bit values in a ring ram
// depends on deq_pkg, deq_ctrl and deq_ram
//
// usage:
//   requests come in on the s_ stream: s_tuser carries the action (push front,
//   push rear, list, pop front, pop rear), s_tdata the value to push.
//   results leave on the m_ stream: m_tdata is the popped or listed value,
//   m_tuser the status (ok, empty, full), m_tlast marks the last result of a
//   request. every request but an unknown action gives at least one result.
//   a push answers in the cycle after it is taken and the next request can
//   follow in the next cycle; a pop's value passes the ram read register and
//   the output register, and no request is taken while the pop state lasts;
//   a list walks the ram one entry a cycle while m_tready stays high.
//   the output register takes a new result as its old one leaves; when
//   m_tready stays low the sequencer holds and s_tready drops.
//   reset clears the pointers and the count; the queue is empty right after,
//   ram contents are not cleared.

module double_ended_queue_unit
    import deq_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [VALUE_W-1:0] s_tdata,   // [31:0] push_value
    input  logic [ACT_W-1:0]   s_tuser,   // [2:0] action
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [VALUE_W-1:0] m_tdata,   // [31:0] value
    output logic [STAT_W-1:0]  m_tuser,   // [1:0] status
    output logic               m_tlast
);

    logic      res_valid;
    logic      res_ready;
    t_result   res;
    t_deq_stat stat;

    logic      r_out_valid, n_out_valid;
    t_result   r_out;

    deq_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req_valid  (s_tvalid),
        .o_req_ready  (s_tready),
        .i_action     (s_tuser),
        .i_push_value (s_tdata),
        .o_res_valid  (res_valid),
        .i_res_ready  (res_ready),
        .o_res        (res),
        .o_stat       (stat)
    );

    assign res_ready = !r_out_valid || m_tready;

    always_comb begin
        n_out_valid = r_out_valid;
        if (res_ready) begin
            n_out_valid = res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_ready && res_valid) begin
            r_out <= res;
        end
    end

    assign m_tvalid = r_out_valid;
    assign m_tdata  = r_out.value;
    assign m_tuser  = r_out.status;
    assign m_tlast  = r_out.last;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        stat.count <= CNT_W'(DEPTH))
        else $error("entry count above depth");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && stat.count != $past(stat.count)) |->
            (stat.count == $past(stat.count) + CNT_W'(1) ||
             stat.count == $past(stat.count) - CNT_W'(1)))
        else $error("entry count moved by more than one");

    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_tready |-> stat.idle)
        else $error("request taken while sequencer busy");

    a_full_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.status == ST_FULL) |->
            (r_out.value == '0 && r_out.last))
        else $error("full status with data or without last");

endmodule

FILE: src/deq_ram.sv
// simple dual-port ram: one write port, one read port with registered data
// generic; no package dependency

module deq_ram #(
    parameter int DEPTH = 32,
    parameter int WIDTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: src/deq_ctrl.sv
// request sequencer: front pointer, entry count and ram access for the deque
// depends on deq_pkg and deq_ram

module deq_ctrl
    import deq_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_req_valid,
    output logic               o_req_ready,
    input  logic [ACT_W-1:0]   i_action,
    input  logic [VALUE_W-1:0] i_push_value,
    output logic               o_res_valid,
    input  logic               i_res_ready,
    output t_result            o_res,
    output t_deq_stat          o_stat
);

    t_state             r_state, n_state;
    logic [PTR_W-1:0]   r_front, n_front;
    logic [CNT_W-1:0]   r_count, n_count;
    logic [PTR_W-1:0]   r_idx,   n_idx;

    logic               wr_en;
    logic [PTR_W-1:0]   wr_addr;
    logic               rd_en;
    logic [PTR_W-1:0]   rd_addr;
    logic [VALUE_W-1:0] rd_data;
    logic               list_last;

    deq_ram #(
        .DEPTH (DEPTH),
        .WIDTH (VALUE_W)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (i_push_value),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_front <= '0;
            r_count <= '0;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            r_front <= n_front;
            r_count <= n_count;
            r_idx   <= n_idx;
        end
    end

    assign list_last = (CNT_W'(r_idx) + CNT_W'(1)) == r_count;

    // one request at a time, so a write always lands before any later read
    always_comb begin
        n_state     = r_state;
        n_front     = r_front;
        n_count     = r_count;
        n_idx       = r_idx;
        o_req_ready = 1'b0;
        o_res_valid = 1'b0;
        o_res       = '{value: '0, status: ST_OK, last: 1'b1};
        wr_en       = 1'b0;
        wr_addr     = r_front;
        rd_en       = 1'b0;
        rd_addr     = r_front;

        case (r_state)
            S_IDLE: begin
                o_req_ready = i_res_ready;
                if (i_req_valid && i_res_ready) begin
                    case (t_action'(i_action))
                        ACT_PUSH_FRONT, ACT_PUSH_REAR: begin
                            o_res_valid = 1'b1;
                            if (r_count == CNT_W'(DEPTH)) begin
                                o_res.status = ST_FULL;
                            end else begin
                                wr_en   = 1'b1;
                                n_count = r_count + CNT_W'(1);
                                if (t_action'(i_action) == ACT_PUSH_FRONT) begin
                                    n_front = (r_front == '0) ? PTR_W'(DEPTH - 1)
                                                              : r_front - PTR_W'(1);
                                    wr_addr = n_front;
                                end else begin
                                    wr_addr = slot_add(r_front, r_count);
                                end
                            end
                        end
                        ACT_LIST: begin
                            if (r_count == '0) begin
                                o_res_valid  = 1'b1;
                                o_res.status = ST_EMPTY;
                            end else begin
                                rd_en   = 1'b1;
                                rd_addr = r_front;
                                n_idx   = '0;
                                n_state = S_LIST;
                            end
                        end
                        ACT_POP_FRONT, ACT_POP_REAR: begin
                            if (r_count == '0) begin
                                o_res_valid  = 1'b1;
                                o_res.status = ST_EMPTY;
                            end else begin
                                rd_en   = 1'b1;
                                n_count = r_count - CNT_W'(1);
                                n_state = S_POP;
                                if (t_action'(i_action) == ACT_POP_FRONT) begin
                                    rd_addr = r_front;
                                    n_front = slot_add(r_front, CNT_W'(1));
                                end else begin
                                    rd_addr = slot_add(r_front, n_count);
                                end
                            end
                        end
                        default: begin
                            // unknown action: taken and dropped
                        end
                    endcase
                end
            end
            S_POP: begin
                o_res_valid = 1'b1;
                o_res.value = rd_data;
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            S_LIST: begin
                // read data holds while the output side stalls
                o_res_valid = 1'b1;
                o_res.value = rd_data;
                o_res.last  = list_last;
                if (i_res_ready) begin
                    if (list_last) begin
                        n_state = S_IDLE;
                    end else begin
                        rd_en   = 1'b1;
                        n_idx   = r_idx + PTR_W'(1);
                        rd_addr = slot_add(r_front, CNT_W'(n_idx));
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_stat = '{count: r_count, idle: (r_state == S_IDLE)};

endmodule

FILE: bench/double_ended_queue_unit_test.sv
`timescale 1ns / 1ps
// stream testbench for double_ended_queue_unit: directed corner requests, then random fill/drain
// phases, checked against an in-bench ring predictor; depends on deq_pkg and the block's rtl

module double_ended_queue_unit_test
    import deq_pkg::*;
;

    localparam logic [ACT_W-1:0] ACT_SPARE_FIRST = 3'd5;  // codes past pop rear are ignored
    localparam logic [ACT_W-1:0] ACT_SPARE_LAST  = 3'd7;
    localparam int RANDOM_REQUESTS = 212;
    localparam int CALM_REQUESTS   = 40;
    localparam int PHASE_LEN       = 40;
    localparam int SETTLE_CYCLES   = 2 * DEPTH + 16;
    localparam int CYCLE_LIMIT     = 700000;

    typedef enum int {
        MODE_FILL,
        MODE_DRAIN,
        MODE_MIXED
    } t_mix;

    // ring model of the queue and the results still owed by the block
    class deque_scoreboard;
        logic [VALUE_W-1:0] ring [DEPTH];
        int unsigned        front_idx;
        int unsigned        live;
        t_result            owed_q[$];
        int unsigned        mismatches;

        function new();
            front_idx  = 0;
            live       = 0;
            mismatches = 0;
        endfunction

        function void owe(logic [VALUE_W-1:0] value, t_status status, logic last);
            t_result r;
            r.value  = value;
            r.status = status;
            r.last   = last;
            owed_q.push_back(r);
        endfunction

        function void note_request(logic [ACT_W-1:0] act, logic [VALUE_W-1:0] push_value);
            int unsigned i;
            case (act)
                ACT_PUSH_FRONT, ACT_PUSH_REAR: begin
                    if (live >= DEPTH) begin
                        owe('0, ST_FULL, 1'b1);
                    end else begin
                        if (act == ACT_PUSH_FRONT) begin
                            front_idx = (front_idx + DEPTH - 1) % DEPTH;
                            ring[front_idx] = push_value;
                        end else begin
                            ring[(front_idx + live) % DEPTH] = push_value;
                        end
                        live++;
                        owe('0, ST_OK, 1'b1);
                    end
                end
                ACT_LIST: begin
                    if (live == 0) begin
                        owe('0, ST_EMPTY, 1'b1);
                    end else begin
                        for (i = 0; i < live; i++) begin
                            owe(ring[(front_idx + i) % DEPTH], ST_OK, i + 1 == live);
                        end
                    end
                end
                ACT_POP_FRONT, ACT_POP_REAR: begin
                    if (live == 0) begin
                        owe('0, ST_EMPTY, 1'b1);
                    end else if (act == ACT_POP_FRONT) begin
                        owe(ring[front_idx], ST_OK, 1'b1);
                        front_idx = (front_idx + 1) % DEPTH;
                        live--;
                    end else begin
                        owe(ring[(front_idx + live - 1) % DEPTH], ST_OK, 1'b1);
                        live--;
                    end
                end
                default: begin
                end
            endcase
        endfunction

        task report(string what);
            mismatches++;
            if (mismatches <= 40) begin
                $display("mismatch at %0t ns: %s", $realtime, what);
            end
        endtask

        task check_result(logic [VALUE_W-1:0] value, logic [STAT_W-1:0] status, logic last);
            t_result want;
            if (owed_q.size() == 0) begin
                report($sformatf("unexpected result value %h status %0d last %0b",
                                 value, status, last));
                return;
            end
            want = owed_q.pop_front();
            if (value !== want.value) begin
                report($sformatf("value got %h want %h", value, want.value));
            end
            if (status !== want.status) begin
                report($sformatf("status got %0d want %0d", status, want.status));
            end
            if (last !== want.last) begin
                report($sformatf("last got %0b want %0b", last, want.last));
            end
        endtask

        function int unsigned pending();
            return owed_q.size();
        endfunction
    endclass

    logic               i_clk;
    logic               i_rst_n  = 1'b0;
    logic               s_tvalid = 1'b0;
    logic               s_tready;
    logic [VALUE_W-1:0] s_tdata  = '0;   // [31:0] push_value
    logic [ACT_W-1:0]   s_tuser  = ACT_LIST;   // [2:0] action
    logic               m_tvalid;
    logic               m_tready = 1'b0;
    logic [VALUE_W-1:0] m_tdata;         // [31:0] value
    logic [STAT_W-1:0]  m_tuser;         // [1:0] status
    logic               m_tlast;

    deque_scoreboard sb = new();
    bit              calm_tail = 1'b0;
    int unsigned     cycles = 0;
    int unsigned     ready_hold = 0;

    double_ended_queue_unit u_top (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // results are checked on the pre-edge values of the output stream
    always @(posedge i_clk) begin
        if (i_rst_n && m_tvalid && m_tready) begin
            sb.check_result(m_tdata, m_tuser, m_tlast);
        end
    end

    // receiver backpressure comes in bursts, switched off for the calm tail
    always @(posedge i_clk) begin
        if (ready_hold > 0) begin
            ready_hold <= ready_hold - 1;
        end else if (calm_tail || !i_rst_n) begin
            m_tready <= i_rst_n;
        end else if ($urandom_range(0, 2) == 0) begin
            m_tready   <= 1'b0;
            ready_hold <= $urandom_range(0, 15);
        end else begin
            m_tready   <= 1'b1;
            ready_hold <= $urandom_range(0, 23);
        end
    end

    // one request, preceded now and then by a burst of idle cycles
    task send_request(logic [ACT_W-1:0] act, logic [VALUE_W-1:0] push_value);
        if (!calm_tail && $urandom_range(0, 9) < 3) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= push_value;
        do @(posedge i_clk); while (!s_tready);
        sb.note_request(act, push_value);
    endtask

    function automatic logic [VALUE_W-1:0] pick_value();
        case ($urandom_range(0, 11))
            0:       return 32'h8000_0000;
            1:       return 32'h7fff_ffff;
            2:       return 32'h0000_0000;
            3:       return 32'hffff_ffff;
            default: return $urandom();
        endcase
    endfunction

    function automatic logic [ACT_W-1:0] pick_action(t_mix mix);
        int unsigned roll;
        int unsigned push_pct;
        int unsigned pop_pct;
        roll = $urandom_range(0, 99);
        case (mix)
            MODE_FILL:  begin push_pct = 80; pop_pct = 10; end
            MODE_DRAIN: begin push_pct = 10; pop_pct = 80; end
            default:    begin push_pct = 45; pop_pct = 45; end
        endcase
        if (roll < push_pct) begin
            return $urandom_range(0, 1) ? ACT_PUSH_FRONT : ACT_PUSH_REAR;
        end else if (roll < push_pct + pop_pct) begin
            return $urandom_range(0, 1) ? ACT_POP_FRONT : ACT_POP_REAR;
        end else if (roll < 96) begin
            return ACT_LIST;
        end
        return ACT_W'($urandom_range(ACT_SPARE_FIRST, ACT_SPARE_LAST));
    endfunction

    initial begin
        t_mix mix;
        int   n;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // empty-queue answers, extreme values, wrap of the front pointer
        send_request(ACT_POP_FRONT, $urandom());
        send_request(ACT_POP_REAR, $urandom());
        send_request(ACT_LIST, $urandom());
        send_request(ACT_PUSH_FRONT, 32'h8000_0000);
        send_request(ACT_PUSH_REAR, 32'h7fff_ffff);
        send_request(ACT_PUSH_FRONT, 32'h0000_0000);
        send_request(ACT_PUSH_REAR, 32'hffff_ffff);
        send_request(ACT_LIST, $urandom());
        send_request(ACT_SPARE_FIRST, 32'h1234_5678);
        send_request(ACT_POP_REAR + 3'd2, 32'hffff_ffff);
        send_request(ACT_SPARE_LAST, 32'h0000_0000);
        send_request(ACT_POP_FRONT, $urandom());
        send_request(ACT_POP_REAR, $urandom());
        send_request(ACT_LIST, $urandom());
        send_request(ACT_POP_REAR, $urandom());
        send_request(ACT_POP_FRONT, $urandom());
        send_request(ACT_POP_FRONT, $urandom());
        send_request(ACT_PUSH_REAR, 32'h5a5a_a5a5);
        send_request(ACT_POP_FRONT, $urandom());

        // fill and drain phases, with a mixed phase among them, push the queue toward full and back toward empty
        for (n = 0; n < RANDOM_REQUESTS; n++) begin
            case ((n / PHASE_LEN) % 4)
                0, 2:    mix = MODE_FILL;
                1:       mix = MODE_DRAIN;
                default: mix = MODE_MIXED;
            endcase
            if (n >= RANDOM_REQUESTS - CALM_REQUESTS) begin
                calm_tail = 1'b1;
            end
            send_request(pick_action(mix), pick_value());
        end
        s_tvalid <= 1'b0;

        while (sb.pending() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (sb.mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
